/* rtl/aaq_pkg.sv */
package aaq_pkg;

	localparam int DEF_OUT_FRAC_BITS   = 14;
	localparam int DEF_TRIG_ITERATIONS = 16;

	// round(2^46 / pi)
	localparam logic [47:0] RAD_K      = 48'd22399066950089;
	localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
	localparam logic [6:0]  DEG_DIV     = 7'd45;

	typedef logic signed [31:0] angle_t;
	typedef logic signed [15:0] axis_t;
	typedef logic signed [15:0] quat_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PHASE = 8'b0000_0010,
		S_NORM  = 8'b0000_0100,
		S_ROOT  = 8'b0000_1000,
		S_TRIG  = 8'b0001_0000,
		S_MUL   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// arctan(2^-i) in phase units, 2^32 per turn
	function automatic logic [29:0] atan_phase(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670163;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/aaq_if.sv */
interface aaq_in_if import aaq_pkg::*; ();
	logic   valid;
	logic   ready;
	angle_t angle;
	logic   in_radians;
	axis_t  axis_x;
	axis_t  axis_y;
	axis_t  axis_z;
	modport source(output valid, angle, in_radians, axis_x, axis_y, axis_z, input ready);
	modport sink(input valid, angle, in_radians, axis_x, axis_y, axis_z, output ready);
endinterface

interface aaq_out_if import aaq_pkg::*; ();
	logic  valid;
	logic  ready;
	quat_t quat_w;
	quat_t quat_x;
	quat_t quat_y;
	quat_t quat_z;
	logic  axis_zero;
	modport source(output valid, quat_w, quat_x, quat_y, quat_z, axis_zero, input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, axis_zero, output ready);
endinterface

/* rtl/axis_angle_to_quaternion.sv */
// axis-angle to unit rotation quaternion
// item channel: angle (Q15.16), in_radians, axis_x/y/z; one transaction per rotation.
// result channel: quat_w/x/y/z (Q1.OUT_FRAC_BITS) and axis_zero; one transaction per item.
// the block works on one item at a time, one bit per cycle through a shared
// shift/subtract datapath:
//   phase: serial multiply (radians) or divide by 45 (degrees)
//   norm: one squarer over the three axis components
//   root: restoring square root
//   trig: TRIG_ITERATIONS cordic rounds, capped at 32
//   divides: 3 restoring divides by the axis length, one per axis component
//   then the transaction is handed to the output register.
// the next item can be taken once the result is in the output register; a zero axis
// skips root, trig and divides and finishes after norm.
// item.ready is high while the block is idle. the output register holds a
// finished result while the receiver stalls, and the next item may be taken
// and worked on meanwhile; it waits at the end only if the register is still full.
// reset empties the output register and returns to idle.
module axis_angle_to_quaternion import aaq_pkg::*; #(
	parameter int OUT_FRAC_BITS   = DEF_OUT_FRAC_BITS,
	parameter int TRIG_ITERATIONS = DEF_TRIG_ITERATIONS
) (
	input logic clk,
	input logic arst_n,
	aaq_in_if.sink item,
	aaq_out_if.source result
);

	localparam int NITER = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam logic [35:0] RND = 36'((64'd1 << SH) >> 1);
	localparam logic [35:0] LIM = 36'(64'd1 << OUT_FRAC_BITS);

	state_t state_q;
	logic [5:0] cnt_q;
	angle_t ang_q;
	logic rad_q, neg_q, sgn_q, zero_q, out_valid_q;
	axis_t ax_q, ay_q, az_q;
	logic signed [46:0] acc_q;
	logic [63:0] dv_q;
	logic [35:0] rem_q;
	logic [31:0] root_q, n2_q;
	logic signed [33:0] x_q, y_q, z_q, c_q, s_q;
	logic [1:0] quad_q, comp_q;
	logic signed [32:0] qx_q, qy_q, qz_q;
	quat_t quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic axis_zero_q;

	function automatic quat_t to_out(input logic signed [34:0] v);
		logic neg;
		logic [35:0] mag;
		quat_t r;
		neg = v[34];
		mag = neg ? 36'(-$signed({v[34], v})) : 36'({v[34], v});
		mag = (mag + RND) >> SH;
		if (mag > LIM)
			mag = LIM;
		if (neg)
			r = (mag > 36'd32768) ? 16'sh8000 : 16'(-$signed(mag));
		else
			r = (mag > 36'd32767) ? 16'sh7fff : mag[15:0];
		return r;
	endfunction

	// phase datapath
	logic rbit;
	logic signed [47:0] addend, rsum;
	logic [6:0] dtrial;
	logic dge;
	logic [43:0] dq_next;
	logic [31:0] phase, ru;
	logic [1:0] quad;
	logic signed [44:0] u45;

	always_comb begin
		u45 = item.angle[31] ? (-45'(signed'({item.angle, 12'b0})) + 45'sd44)
			: 45'(signed'({item.angle, 12'b0}));
		rbit = ang_q[cnt_q[4:0]];
		addend = '0;
		if (rbit)
			addend = (cnt_q == 6'd31) ? -$signed(RAD_K) : $signed(RAD_K);
		rsum = 48'(acc_q) + addend;
		dtrial = {rem_q[5:0], dv_q[43]};
		dge = dtrial >= DEG_DIV;
		dq_next = {dv_q[42:0], dge};
		if (rad_q)
			phase = rsum[32:1];
		else
			phase = neg_q ? -dq_next[31:0] : dq_next[31:0];
		quad = 2'((phase + 32'h2000_0000) >> 30);
		ru = phase - {quad, 30'b0};
	end

	// norm and root datapath
	axis_t comp;
	logic [31:0] sq, n2_new;
	logic [35:0] rremn;
	logic [33:0] rtrial;
	logic rge;

	always_comb begin
		case (comp_q)
			2'd0: comp = ax_q;
			2'd1: comp = ay_q;
			default: comp = az_q;
		endcase
		sq = 32'(comp) * 32'(comp);
		n2_new = n2_q + sq;
		rremn = {rem_q[33:0], dv_q[63:62]};
		rtrial = {root_q, 2'b01};
		rge = rremn >= {2'b0, rtrial};
	end

	// cordic datapath
	logic [4:0] it;
	logic signed [33:0] xs, ys, xn, yn, zn, at;

	always_comb begin
		it = cnt_q[4:0];
		xs = x_q >>> it;
		ys = y_q >>> it;
		at = $signed({4'b0, atan_phase(it)});
		if (!z_q[33]) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - at;
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + at;
		end
	end

	// divide datapath
	logic [16:0] ma;
	logic [31:0] ms;
	logic [63:0] nprod;
	logic [32:0] dremn;
	logic qge;
	logic [31:0] qn;
	logic signed [32:0] qsigned;

	always_comb begin
		ma = comp[15] ? 17'(-$signed({comp[15], comp})) : 17'({comp[15], comp});
		ms = s_q[33] ? 32'(-s_q) : 32'(s_q);
		nprod = (64'(ma) * 64'(ms)) << 15;
		dremn = {rem_q[31:0], dv_q[31]};
		qge = dremn >= {1'b0, root_q};
		qn = {dv_q[30:0], qge};
		qsigned = sgn_q ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
	end

	logic load_out;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			comp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						cnt_q <= '0;
						state_q <= S_PHASE;
					end
				end
				S_PHASE: begin
					if ((rad_q && cnt_q == 6'd31) || (!rad_q && cnt_q == 6'd43)) begin
						cnt_q <= '0;
						comp_q <= '0;
						state_q <= S_NORM;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_NORM: begin
					if (comp_q == 2'd2) begin
						comp_q <= '0;
						state_q <= (n2_new == '0) ? S_DONE : S_ROOT;
					end else
						comp_q <= comp_q + 2'd1;
				end
				S_ROOT: begin
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						state_q <= S_TRIG;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_TRIG: begin
					if (cnt_q == 6'(NITER - 1)) begin
						cnt_q <= '0;
						state_q <= S_MUL;
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_MUL: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 6'd31) begin
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							comp_q <= '0;
							state_q <= S_DONE;
						end else begin
							comp_q <= comp_q + 2'd1;
							state_q <= S_MUL;
						end
					end else
						cnt_q <= cnt_q + 6'd1;
				end
				S_DONE: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ang_q <= item.angle;
				rad_q <= item.in_radians;
				ax_q <= item.axis_x;
				ay_q <= item.axis_y;
				az_q <= item.axis_z;
				neg_q <= item.angle[31];
				acc_q <= '0;
				rem_q <= '0;
				dv_q <= {20'b0, u45[43:0]};
			end
			S_PHASE: begin
				acc_q <= rsum[47:1];
				rem_q <= {29'b0, dge ? dtrial - DEG_DIV : dtrial};
				dv_q <= {20'b0, dq_next};
				quad_q <= quad;
				z_q <= 34'(signed'(ru));
				x_q <= $signed(CORDIC_GAIN);
				y_q <= '0;
				n2_q <= '0;
			end
			S_NORM: begin
				n2_q <= n2_new;
				zero_q <= n2_new == '0;
				dv_q <= {2'b0, n2_new, 30'b0};
				rem_q <= '0;
				root_q <= '0;
			end
			S_ROOT: begin
				dv_q <= {dv_q[61:0], 2'b0};
				root_q <= {root_q[30:0], rge};
				rem_q <= rge ? rremn - {2'b0, rtrial} : rremn;
			end
			S_TRIG: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
				if (cnt_q == 6'(NITER - 1)) begin
					case (quad_q)
						2'd1: begin c_q <= -yn; s_q <= xn; end
						2'd2: begin c_q <= -xn; s_q <= -yn; end
						2'd3: begin c_q <= yn; s_q <= -xn; end
						default: begin c_q <= xn; s_q <= yn; end
					endcase
				end
			end
			S_MUL: begin
				rem_q <= {4'b0, nprod[63:32]};
				dv_q <= {32'b0, nprod[31:0]};
				sgn_q <= comp[15] ^ s_q[33];
			end
			S_DIV: begin
				rem_q <= {4'b0, qge ? 32'(dremn - {1'b0, root_q}) : dremn[31:0]};
				dv_q <= {32'b0, qn};
				if (cnt_q == 6'd31) begin
					case (comp_q)
						2'd0: qx_q <= qsigned;
						2'd1: qy_q <= qsigned;
						default: qz_q <= qsigned;
					endcase
				end
			end
			default: ;
		endcase
		if (load_out) begin
			axis_zero_q <= zero_q;
			quat_w_q <= zero_q ? '0 : to_out(35'(c_q));
			quat_x_q <= zero_q ? '0 : to_out(35'(qx_q));
			quat_y_q <= zero_q ? '0 : to_out(35'(qy_q));
			quat_z_q <= zero_q ? '0 : to_out(35'(qz_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	assign item.ready = state_q == S_IDLE;
	assign result.valid = out_valid_q;
	assign result.quat_w = quat_w_q;
	assign result.quat_x = quat_x_q;
	assign result.quat_y = quat_y_q;
	assign result.quat_z = quat_z_q;
	assign result.axis_zero = axis_zero_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q == S_PHASE)
		else $error("accepted transaction did not start phase");

	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROOT |-> n2_q != '0)
		else $error("square root entered with zero axis");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.axis_zero |-> result.quat_w == '0 && result.quat_x == '0
			&& result.quat_y == '0 && result.quat_z == '0)
		else $error("zero axis result carries nonzero quaternion");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> $stable(quat_w_q) && $stable(axis_zero_q))
		else $error("pending result overwritten");

endmodule

/* verif/tb_top.sv */
module tb_top;
	import aaq_pkg::*;

	localparam int FRAC = DEF_OUT_FRAC_BITS;
	localparam int ITERS = DEF_TRIG_ITERATIONS;
	localparam int N_ITEMS = 950;

	typedef struct {
		logic [15:0] w;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        zero;
	} result_item_t;

	class quat_scoreboard;
		result_item_t pending[$];
		int errors;

		function void note_rotation(result_item_t q);
			pending.push_back(q);
		endfunction

		function void check_quat(result_item_t got);
			result_item_t e;
			if (pending.size() == 0) begin
				$error("result transaction with nothing pending");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.w !== e.w) begin
				$error("quat_w expected %0d actual %0d", $signed(e.w), $signed(got.w));
				errors++;
			end
			if (got.x !== e.x) begin
				$error("quat_x expected %0d actual %0d", $signed(e.x), $signed(got.x));
				errors++;
			end
			if (got.y !== e.y) begin
				$error("quat_y expected %0d actual %0d", $signed(e.y), $signed(got.y));
				errors++;
			end
			if (got.z !== e.z) begin
				$error("quat_z expected %0d actual %0d", $signed(e.z), $signed(got.z));
				errors++;
			end
			if (got.zero !== e.zero) begin
				$error("axis_zero expected %0d actual %0d", e.zero, got.zero);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	aaq_in_if item();
	aaq_out_if result();

	axis_angle_to_quaternion dut (.clk(clk), .arst_n(arst_n), .item(item), .result(result));

	always #2 clk = ~clk;

	quat_scoreboard sb = new();
	bit sent_all = 0;
	bit hold_long = 0;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_tab(int i);
		longint tab[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1, 1, 0};
		return tab[i];
	endfunction

	function automatic logic [15:0] round_out(longint v30);
		longint mag, r;
		int sh;
		sh = 30 - FRAC;
		mag = v30 < 0 ? -v30 : v30;
		if (sh > 0) mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		if (mag > (64'sd1 <<< FRAC)) mag = 64'sd1 <<< FRAC;
		r = v30 < 0 ? -mag : mag;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic longint axis_part(longint a, longint s, longint unsigned rt);
		longint unsigned ma, ms;
		longint q;
		ma = a < 0 ? -a : a;
		ms = s < 0 ? -s : s;
		q = ((ma * ms) << 15) / rt;
		return ((a < 0) != (s < 0)) ? -q : q;
	endfunction

	function automatic result_item_t rotation_of(angle_t ang, logic rad, axis_t ax, axis_t ay,
		axis_t az);
		result_item_t q;
		logic [31:0] phase, ru;
		logic [1:0] quad;
		longint a, t, d, x, y, z, nx, tmp;
		longint unsigned n2, n, rem, rt, tt;
		logic [95:0] prod;
		int lim;
		a = ang;
		if (rad) begin
			prod = $signed({{16{ang[31]}}, ang}) * $signed({1'b0, RAD_K});
			phase = prod[63:32];
		end else begin
			t = a * 4096;
			d = t / 45;
			if (t % 45 != 0 && t < 0) d = d - 1;
			phase = d[31:0];
		end
		n2 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
		if (n2 == 0) begin
			q = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
			return q;
		end
		n = n2 << 30;
		rem = 0;
		rt = 0;
		for (int i = 0; i < 32; i++) begin
			rt = rt << 1;
			rem = (rem << 2) | (n >> 62);
			n = n << 2;
			tt = (rt << 1) | 1;
			if (rem >= tt) begin
				rem -= tt;
				rt |= 1;
			end
		end
		quad = 2'((phase + 32'h2000_0000) >> 30);
		ru = phase - {quad, 30'd0};
		z = $signed(ru);
		x = CORDIC_GAIN;
		y = 0;
		lim = ITERS > 32 ? 32 : ITERS;
		for (int i = 0; i < lim; i++) begin
			if (z >= 0) begin
				nx = x - fshift(y, i);
				y = y + fshift(x, i);
				z -= atan_tab(i);
			end else begin
				nx = x + fshift(y, i);
				y = y - fshift(x, i);
				z += atan_tab(i);
			end
			x = nx;
		end
		case (quad)
			2'd1: begin tmp = x; x = -y; y = tmp; end
			2'd2: begin x = -x; y = -y; end
			2'd3: begin tmp = x; x = y; y = -tmp; end
			default: ;
		endcase
		q.w = round_out(x);
		q.x = round_out(axis_part(ax, y, rt));
		q.y = round_out(axis_part(ay, y, rt));
		q.z = round_out(axis_part(az, y, rt));
		q.zero = 1'b0;
		return q;
	endfunction

	task automatic send_rotation(angle_t ang, logic rad, axis_t ax, axis_t ay, axis_t az);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			item.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1;
		item.angle <= ang;
		item.in_radians <= rad;
		item.axis_x <= ax;
		item.axis_y <= ay;
		item.axis_z <= az;
		do @(posedge clk); while (!item.ready);
		sb.note_rotation(rotation_of(ang, rad, ax, ay, az));
	endtask

	function automatic axis_t rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		item.valid = 0;
		item.angle = 0;
		item.in_radians = 0;
		item.axis_x = 0;
		item.axis_y = 0;
		item.axis_z = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_rotation(0, 1'b0, 16'sd1, 16'sd0, 16'sd0);
		send_rotation(0, 1'b0, 16'sd0, 16'sd0, 16'sd0);
		send_rotation(0, 1'b1, 16'sd0, 16'sd0, 16'sd0);
		send_rotation(32'sh7fffffff, 1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_rotation(32'sh80000000, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
		send_rotation(32'sh7fffffff, 1'b1, 16'sh8000, 16'sd0, 16'sd0);
		send_rotation(32'sh80000000, 1'b1, 16'sd0, 16'sh7fff, 16'sd0);
		send_rotation(180 <<< 16, 1'b0, 16'sd0, 16'sd0, 16'sd5);
		send_rotation(-(180 <<< 16), 1'b0, 16'sd0, 16'sd0, -16'sd5);
		send_rotation(90 <<< 16, 1'b0, 16'sd3, 16'sd4, 16'sd0);
		send_rotation(360 <<< 16, 1'b0, 16'sd1, 16'sd1, 16'sd1);
		send_rotation(720 <<< 16, 1'b0, -16'sd1, 16'sd2, -16'sd3);
		send_rotation(-1, 1'b0, 16'sd1, 16'sd0, 16'sd0);
		send_rotation(-1, 1'b1, 16'sd0, 16'sd1, 16'sd0);
		send_rotation(205887, 1'b1, 16'sd0, 16'sd0, 16'sd1);
		send_rotation(411775, 1'b1, 16'sd7, 16'sd0, 16'sd0);
		send_rotation(-45, 1'b0, 16'sh8000, 16'sh7fff, 16'sd1);
		send_rotation(45 <<< 16, 1'b0, -16'sd1, -16'sd1, -16'sd1);
		for (int i = 0; i < N_ITEMS; i++) begin
			angle_t a;
			if (i == 300) hold_long = 1;
			a = $urandom_range(0, 3) == 0 ? angle_t'($urandom)
				: $signed(32'($urandom_range(0, 1440 << 16))) - (720 <<< 16);
			send_rotation(a, 1'($urandom_range(0, 1)), rand_axis(), rand_axis(), rand_axis());
		end
		item.valid <= 0;
		sent_all = 1;
	end

	initial begin
		int gap;
		bit held;
		held = 0;
		result.ready = 0;
		wait (arst_n);
		forever begin
			if (hold_long && !held) begin
				held = 1;
				result.ready <= 0;
				repeat (3000) @(posedge clk);
			end
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				result.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			result.ready <= 1;
			do @(posedge clk); while (!result.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_quat('{result.quat_w, result.quat_x, result.quat_y, result.quat_z,
				result.axis_zero});
	end

	initial begin
		wait (sent_all);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
